// ===== design/jss_pkg.sv =====
// ----------------------------------------------------------------------------
// jss_pkg: shared types and constants of the job shop scheduler
// Field widths, register and item codes, feature slots and the sequencer
// state type.
// ----------------------------------------------------------------------------
package jss_pkg;

  // fixed field widths
  localparam int TIME_W       = 18;
  localparam int END_W        = 20;
  localparam int PT_W         = 12;
  localparam int WT_W         = 16;
  localparam int PHI_W        = 19;
  localparam int PROD_W       = PHI_W + 1 + WT_W;
  localparam int SCORE_W      = 40;
  localparam int CNT_W        = 4;
  localparam int STEP_W       = 7;
  localparam int CFG_W        = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int NUM_FEATURES = 14;
  localparam int FEAT_IDX_W   = 4;
  localparam int MAX_RESULTS  = 64;

  localparam logic [END_W-1:0] OPEN_END = 20'hFFFFF;
  localparam logic [CNT_W-1:0] CNT_MAX  = 4'd15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JOBS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MACHINES = 1'b1;

  // input item kinds
  localparam logic [1:0] KIND_LOAD_OP     = 2'd0;
  localparam logic [1:0] KIND_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_RUN         = 2'd2;

  // feature slots
  localparam int FEAT_MACHINE    = 0;
  localparam int FEAT_START      = 1;
  localparam int FEAT_READY      = 2;
  localparam int FEAT_WORK_LEFT  = 3;
  localparam int FEAT_PTIME      = 4;
  localparam int FEAT_OPS_DONE   = 5;
  localparam int FEAT_WORK_TOTAL = 6;
  localparam int FEAT_WAIT       = 7;
  localparam int FEAT_INSERT     = 8;
  localparam int FEAT_MACH_FIN   = 9;
  localparam int FEAT_MAKESPAN   = 10;
  localparam int FEAT_MACH_WORK  = 11;
  localparam int FEAT_GAP        = 12;
  localparam int FEAT_FINISH     = 13;

  typedef logic [NUM_FEATURES-1:0][PHI_W-1:0] phi_vec_t;

  typedef struct packed {
    logic                         start;
    logic                         wr_en;
    logic [FEAT_IDX_W-1:0]        wr_index;
    logic signed [WT_W-1:0]       wr_value;
  } score_ctl_t;

  typedef struct packed {
    logic                         done;
    logic signed [SCORE_W-1:0]    score;
  } score_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SUM_RD,
    ST_SUM_ADD,
    ST_JOB,
    ST_MACH,
    ST_PTIME,
    ST_SLOT_RD,
    ST_SLOT_EV,
    ST_SCORE,
    ST_SCORE_WAIT,
    ST_COMMIT,
    ST_SPLIT
  } state_t;

endpackage

// ===== design/jss_if.sv =====
// ----------------------------------------------------------------------------
// jss_if: input and result channels of the job shop scheduler
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface jss_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [2:0]        job_index;
  logic [2:0]        op_index;
  logic [2:0]        machine_id;
  logic [11:0]       proc_time;
  logic [3:0]        weight_index;
  logic signed [15:0] weight_value;

  modport source (output valid, kind, job_index, op_index, machine_id, proc_time,
                  weight_index, weight_value, input ready);
  modport sink (input valid, kind, job_index, op_index, machine_id, proc_time,
                weight_index, weight_value, output ready);
endinterface

interface jss_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  step_job;
  logic [2:0]  step_machine;
  logic [17:0] start_time;
  logic [5:0]  var_index;
  logic [17:0] used_slot_start;
  logic [19:0] used_slot_end;
  logic [17:0] makespan;
  logic        last;

  modport source (output valid, step_job, step_machine, start_time, var_index,
                  used_slot_start, used_slot_end, makespan, last, input ready);
  modport sink (input valid, step_job, step_machine, start_time, var_index,
                used_slot_start, used_slot_end, makespan, last, output ready);
endinterface

// ===== design/jss_ram.sv =====
// ----------------------------------------------------------------------------
// jss_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/jss_score.sv =====
// ----------------------------------------------------------------------------
// jss_score: weighted feature sum
// Holds the fourteen Q8.8 weights and sums feature times weight with one
// shared multiplier, one feature per cycle.
// ----------------------------------------------------------------------------
module jss_score (
  input  logic                   clk,
  input  logic                   rst,
  input  jss_pkg::score_ctl_t    ctl,
  input  jss_pkg::phi_vec_t      phi,
  output jss_pkg::score_stat_t   stat
);

  logic signed [jss_pkg::WT_W-1:0]    weights [jss_pkg::NUM_FEATURES];
  jss_pkg::phi_vec_t                  phi_q;
  logic [jss_pkg::FEAT_IDX_W-1:0]     k;
  logic                               busy;
  logic signed [jss_pkg::PROD_W-1:0]  prod;
  logic                               prod_v;
  logic                               prod_last;
  logic signed [jss_pkg::SCORE_W-1:0] acc;
  logic                               done;

  // weight storage
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_index < jss_pkg::FEAT_IDX_W'(jss_pkg::NUM_FEATURES))) begin
      weights[ctl.wr_index] <= ctl.wr_value;
    end
  end

  // sequencing of the feature walk
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      prod_v <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= prod_v && prod_last;
      prod_v <= busy;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && (k == jss_pkg::FEAT_IDX_W'(jss_pkg::NUM_FEATURES - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  // multiply then accumulate
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      phi_q <= phi;
      k     <= '0;
      acc   <= '0;
    end else begin
      if (busy) begin
        k <= k + 1'b1;
      end
      if (prod_v) begin
        acc <= acc + jss_pkg::SCORE_W'(prod);
      end
    end
    prod      <= $signed({1'b0, phi_q[k]}) * weights[k];
    prod_last <= (k == jss_pkg::FEAT_IDX_W'(jss_pkg::NUM_FEATURES - 1));
  end

  assign stat.done  = done;
  assign stat.score = acc;

endmodule

// ===== design/job_shop_insertion_scheduler.sv =====
// ----------------------------------------------------------------------------
// job_shop_insertion_scheduler: job shop list scheduler with slot insertion
// Stores routings, processing times and feature weights, and on a run
// builds the schedule one dispatched operation at a time.
// ----------------------------------------------------------------------------
// Load words (operation or weight) are taken one per cycle while the block is
// idle. A run word first opens slot 0 of every machine and sums the work
// tables, one processing time memory read per entry. Each of the n*m steps
// then visits every unfinished job: the routing and time reads, a read and an
// evaluation per idle slot examined on the job's machine, and the 14 feature
// score in the shared multiply-accumulate unit. The chosen job then commits
// and splits its slot, the commit waiting while the previous result word is
// still untaken. The block takes no word until the last result of a run is
// committed.
module job_shop_insertion_scheduler #(
  parameter int MAX_JOBS     = 8,
  parameter int MAX_MACHINES = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [jss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jss_pkg::CFG_W-1:0]      cfg_data,
  jss_in_if.sink                         in_ch,
  jss_out_if.source                      out_ch
);

  localparam int JW    = $clog2(MAX_JOBS);
  localparam int MW    = $clog2(MAX_MACHINES);
  localparam int NW    = $clog2(MAX_JOBS + 1);
  localparam int MCW   = $clog2(MAX_MACHINES + 1);
  localparam int OPD   = 1 << (JW + MW);
  localparam int TIME_W = jss_pkg::TIME_W;
  localparam int END_W  = jss_pkg::END_W;
  localparam int SLOT_W = TIME_W + END_W;

  jss_pkg::state_t state, state_next;

  // configuration
  logic [jss_pkg::CFG_W-1:0] jobs_in_use, machines_in_use;
  logic [NW-1:0]  n_clamp, n_use, n_m1;
  logic [MCW-1:0] m_clamp, m_use;
  logic [jss_pkg::STEP_W-1:0] total, step_cnt;

  // schedule state
  logic [TIME_W-1:0]        job_ready  [MAX_JOBS];
  logic [MCW-1:0]           job_ops    [MAX_JOBS];
  logic [TIME_W-1:0]        job_left   [MAX_JOBS];
  logic [TIME_W-1:0]        job_total  [MAX_JOBS];
  logic [TIME_W-1:0]        mach_fin   [MAX_MACHINES];
  logic [jss_pkg::CNT_W-1:0] mach_ops  [MAX_MACHINES];
  logic [TIME_W-1:0]        mach_left  [MAX_MACHINES];
  logic [TIME_W-1:0]        makespan;

  // sequencer counters and candidate
  logic [MW-1:0]  clr_idx, sum_i, cur_mac;
  logic [JW-1:0]  sum_j, cur_job, s_idx, limit, c_slot;
  logic [jss_pkg::PT_W-1:0] cur_p;
  logic           c_found;
  logic [END_W-1:0]  c_gap, c_sf;
  logic [TIME_W-1:0] c_sb;

  // best candidate of the step
  logic           have;
  logic [JW-1:0]  best_job, best_slot;
  logic [MW-1:0]  best_mac;
  logic [TIME_W-1:0] best_start, best_sb;
  logic [END_W-1:0]  best_sf;
  logic [jss_pkg::PT_W-1:0] best_p;
  logic signed [jss_pkg::SCORE_W-1:0] best_v;
  logic           fin_step;

  // result register
  logic        out_valid;
  logic [2:0]  o_job, o_mac;
  logic [17:0] o_start, o_ub, o_mk;
  logic [5:0]  o_var;
  logic [19:0] o_ue;
  logic        o_last;

  // memories
  logic             opm_we, opt_we, slot_we;
  logic [JW+MW-1:0] opm_waddr, opt_waddr, opm_raddr, opt_raddr;
  logic [JW+MW-1:0] slot_waddr, slot_raddr;
  logic [MW-1:0]    opm_rdata;
  logic [jss_pkg::PT_W-1:0] opt_rdata;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;

  jss_pkg::score_ctl_t  score_ctl;
  jss_pkg::score_stat_t score_stat;
  jss_pkg::phi_vec_t    phi;

  // shared read selects and looked-up values
  logic [JW-1:0]     job_rd;
  logic [MW-1:0]     mac_rd;
  logic [TIME_W-1:0] r_ready, r_jleft, r_jtotal, r_mfin, r_mleft;
  logic [MCW-1:0]    r_jops;
  logic [jss_pkg::CNT_W-1:0] r_mops;

  logic in_fire, last_job, job_finished, out_free, commit_fire, sum_last;
  logic [MW-1:0]     mac_clamp;
  logic [TIME_W-1:0] slot_sb, lo, start_c, sp_c, mfin_c, mk_c, best_sp, fin_new, mk_new;
  logic [END_W-1:0]  slot_sf, gap;
  logic              fits;
  logic [4:0]        lim_wide;
  logic              split_next;

  jss_ram #(.WIDTH(MW), .DEPTH(OPD)) u_op_mach (
    .clk(clk), .we(opm_we), .waddr(opm_waddr), .wdata(MW'(in_ch.machine_id)),
    .raddr(opm_raddr), .rdata(opm_rdata)
  );

  jss_ram #(.WIDTH(jss_pkg::PT_W), .DEPTH(OPD)) u_op_time (
    .clk(clk), .we(opt_we), .waddr(opt_waddr), .wdata(in_ch.proc_time),
    .raddr(opt_raddr), .rdata(opt_rdata)
  );

  jss_ram #(.WIDTH(SLOT_W), .DEPTH(OPD)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  jss_score u_score (
    .clk(clk), .rst(rst), .ctl(score_ctl), .phi(phi), .stat(score_stat)
  );

  // register clamps
  always_comb begin
    if (jobs_in_use == '0) n_clamp = NW'(1);
    else if (32'(jobs_in_use) > MAX_JOBS) n_clamp = NW'(MAX_JOBS);
    else n_clamp = NW'(jobs_in_use);
    if (machines_in_use == '0) m_clamp = MCW'(1);
    else if (32'(machines_in_use) > MAX_MACHINES) m_clamp = MCW'(MAX_MACHINES);
    else m_clamp = MCW'(machines_in_use);
  end

  assign n_m1 = n_use - 1'b1;

  // read selects
  always_comb begin
    if (state == jss_pkg::ST_SUM_RD || state == jss_pkg::ST_SUM_ADD) begin
      job_rd = sum_j;
      mac_rd = sum_i;
    end else if (state == jss_pkg::ST_COMMIT || state == jss_pkg::ST_SPLIT) begin
      job_rd = best_job;
      mac_rd = best_mac;
    end else begin
      job_rd = cur_job;
      mac_rd = cur_mac;
    end
  end

  assign r_ready  = job_ready[job_rd];
  assign r_jops   = job_ops[job_rd];
  assign r_jleft  = job_left[job_rd];
  assign r_jtotal = job_total[job_rd];
  assign r_mfin   = mach_fin[mac_rd];
  assign r_mops   = mach_ops[mac_rd];
  assign r_mleft  = mach_left[mac_rd];

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign last_job     = (NW'(cur_job) + NW'(1)) == n_use;
  assign job_finished = r_jops >= m_use;
  assign sum_last     = (MCW'(sum_i) + MCW'(1) == m_use) && (NW'(sum_j) + NW'(1) == n_use);
  assign out_free     = !out_valid || out_ch.ready;
  assign commit_fire  = (state == jss_pkg::ST_COMMIT) && out_free;
  assign mac_clamp    = (MCW'(opm_rdata) >= m_use) ? MW'(m_use - 1'b1) : opm_rdata;
  assign split_next   = (32'(r_mops) < 32'(n_m1));

  // slot evaluation
  assign slot_sb = slot_rdata[SLOT_W-1:END_W];
  assign slot_sf = slot_rdata[END_W-1:0];
  assign lo      = (slot_sb > r_ready) ? slot_sb : r_ready;
  assign fits    = slot_sf >= (END_W'(lo) + END_W'(cur_p));
  assign gap     = slot_sf - END_W'(lo);
  assign lim_wide = (5'(r_mops) < 5'(n_m1)) ? 5'(r_mops) : 5'(n_m1);

  // candidate timing
  assign start_c = (r_ready > c_sb) ? r_ready : c_sb;
  assign sp_c    = start_c + TIME_W'(cur_p);
  assign mfin_c  = (r_mfin > sp_c) ? r_mfin : sp_c;
  assign mk_c    = (makespan > mfin_c) ? makespan : mfin_c;

  // commit timing
  assign best_sp = best_start + TIME_W'(best_p);
  assign fin_new = (r_mfin > best_sp) ? r_mfin : best_sp;
  assign mk_new  = (makespan > fin_new) ? makespan : fin_new;

  // feature vector
  always_comb begin
    phi = '0;
    phi[jss_pkg::FEAT_MACHINE]    = jss_pkg::PHI_W'(cur_mac) + 1'b1;
    phi[jss_pkg::FEAT_START]      = jss_pkg::PHI_W'(start_c);
    phi[jss_pkg::FEAT_READY]      = jss_pkg::PHI_W'(r_ready);
    phi[jss_pkg::FEAT_WORK_LEFT]  = jss_pkg::PHI_W'(r_jleft);
    phi[jss_pkg::FEAT_PTIME]      = jss_pkg::PHI_W'(cur_p);
    phi[jss_pkg::FEAT_OPS_DONE]   = jss_pkg::PHI_W'(r_jops);
    phi[jss_pkg::FEAT_WORK_TOTAL] = jss_pkg::PHI_W'(r_jtotal);
    phi[jss_pkg::FEAT_WAIT]       = jss_pkg::PHI_W'(start_c - r_ready);
    phi[jss_pkg::FEAT_INSERT]     = jss_pkg::PHI_W'(c_sf != jss_pkg::OPEN_END);
    phi[jss_pkg::FEAT_MACH_FIN]   = jss_pkg::PHI_W'(mfin_c);
    phi[jss_pkg::FEAT_MAKESPAN]   = jss_pkg::PHI_W'(mk_c);
    phi[jss_pkg::FEAT_MACH_WORK]  = jss_pkg::PHI_W'(r_mleft);
    phi[jss_pkg::FEAT_GAP]        = jss_pkg::PHI_W'(start_c - c_sb);
    phi[jss_pkg::FEAT_FINISH]     = jss_pkg::PHI_W'(sp_c);
  end

  // score unit control
  always_comb begin
    score_ctl.start    = (state == jss_pkg::ST_SCORE);
    score_ctl.wr_en    = in_fire && (in_ch.kind == jss_pkg::KIND_LOAD_WEIGHT);
    score_ctl.wr_index = in_ch.weight_index;
    score_ctl.wr_value = in_ch.weight_value;
  end

  // memory ports
  always_comb begin
    opm_we    = in_fire && (in_ch.kind == jss_pkg::KIND_LOAD_OP)
                && (32'(in_ch.job_index) < MAX_JOBS) && (32'(in_ch.op_index) < MAX_MACHINES)
                && (32'(in_ch.machine_id) < MAX_MACHINES);
    opt_we    = opm_we;
    opm_waddr = {JW'(in_ch.job_index), MW'(in_ch.op_index)};
    opt_waddr = {JW'(in_ch.job_index), MW'(in_ch.machine_id)};
    opm_raddr = {cur_job, MW'(r_jops)};
    opt_raddr = (state == jss_pkg::ST_SUM_RD) ? {sum_j, sum_i} : {cur_job, mac_clamp};
    slot_raddr = {cur_mac, s_idx};
    slot_we    = 1'b0;
    slot_waddr = {clr_idx, JW'(0)};
    slot_wdata = {TIME_W'(0), jss_pkg::OPEN_END};
    unique case (state)
      jss_pkg::ST_CLEAR: begin
        slot_we = 1'b1;
      end
      jss_pkg::ST_COMMIT: begin
        slot_we    = commit_fire && split_next;
        slot_waddr = {best_mac, JW'(r_mops + 1'b1)};
        slot_wdata = {best_sp, best_sf};
      end
      jss_pkg::ST_SPLIT: begin
        slot_we    = 1'b1;
        slot_waddr = {best_mac, best_slot};
        slot_wdata = {best_sb, END_W'(best_start)};
      end
      default: begin
        slot_we = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      jss_pkg::ST_IDLE: begin
        if (in_fire && in_ch.kind == jss_pkg::KIND_RUN) state_next = jss_pkg::ST_CLEAR;
      end
      jss_pkg::ST_CLEAR: begin
        if (clr_idx == MW'(MAX_MACHINES - 1)) state_next = jss_pkg::ST_SUM_RD;
      end
      jss_pkg::ST_SUM_RD: state_next = jss_pkg::ST_SUM_ADD;
      jss_pkg::ST_SUM_ADD: begin
        state_next = sum_last ? jss_pkg::ST_JOB : jss_pkg::ST_SUM_RD;
      end
      jss_pkg::ST_JOB: begin
        if (!job_finished) state_next = jss_pkg::ST_MACH;
        else if (last_job) state_next = have ? jss_pkg::ST_COMMIT : jss_pkg::ST_IDLE;
      end
      jss_pkg::ST_MACH: state_next = jss_pkg::ST_PTIME;
      jss_pkg::ST_PTIME: state_next = jss_pkg::ST_SLOT_RD;
      jss_pkg::ST_SLOT_RD: state_next = jss_pkg::ST_SLOT_EV;
      jss_pkg::ST_SLOT_EV: begin
        if (s_idx == limit) state_next = jss_pkg::ST_SCORE;
        else state_next = jss_pkg::ST_SLOT_RD;
      end
      jss_pkg::ST_SCORE: state_next = jss_pkg::ST_SCORE_WAIT;
      jss_pkg::ST_SCORE_WAIT: begin
        if (score_stat.done) state_next = last_job ? jss_pkg::ST_COMMIT : jss_pkg::ST_JOB;
      end
      jss_pkg::ST_COMMIT: begin
        if (out_free) state_next = jss_pkg::ST_SPLIT;
      end
      jss_pkg::ST_SPLIT: state_next = fin_step ? jss_pkg::ST_IDLE : jss_pkg::ST_JOB;
      default: state_next = jss_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      jobs_in_use     <= jss_pkg::CFG_W'(8);
      machines_in_use <= jss_pkg::CFG_W'(8);
    end else if (cfg_write) begin
      unique case (cfg_index)
        jss_pkg::REG_JOBS:     jobs_in_use     <= cfg_data;
        jss_pkg::REG_MACHINES: machines_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      jss_pkg::ST_IDLE: begin
        if (in_fire && in_ch.kind == jss_pkg::KIND_RUN) begin
          n_use    <= n_clamp;
          m_use    <= m_clamp;
          total    <= (32'(n_clamp) * 32'(m_clamp) > jss_pkg::MAX_RESULTS)
                      ? jss_pkg::STEP_W'(jss_pkg::MAX_RESULTS)
                      : jss_pkg::STEP_W'(32'(n_clamp) * 32'(m_clamp));
          makespan <= '0;
          clr_idx  <= '0;
          for (int j = 0; j < MAX_JOBS; j++) begin
            job_ready[j] <= '0;
            job_ops[j]   <= '0;
            job_left[j]  <= '0;
            job_total[j] <= '0;
          end
          for (int i = 0; i < MAX_MACHINES; i++) begin
            mach_fin[i]  <= '0;
            mach_ops[i]  <= '0;
            mach_left[i] <= '0;
          end
        end
      end
      jss_pkg::ST_CLEAR: begin
        clr_idx <= clr_idx + 1'b1;
        sum_j   <= '0;
        sum_i   <= '0;
      end
      jss_pkg::ST_SUM_RD: ;
      jss_pkg::ST_SUM_ADD: begin
        job_left[sum_j]  <= r_jleft + TIME_W'(opt_rdata);
        job_total[sum_j] <= r_jtotal + TIME_W'(opt_rdata);
        mach_left[sum_i] <= r_mleft + TIME_W'(opt_rdata);
        if (MCW'(sum_i) + MCW'(1) == m_use) begin
          sum_i <= '0;
          sum_j <= sum_j + 1'b1;
        end else begin
          sum_i <= sum_i + 1'b1;
        end
        cur_job  <= '0;
        have     <= 1'b0;
        step_cnt <= '0;
      end
      jss_pkg::ST_JOB: begin
        if (job_finished && !last_job) cur_job <= cur_job + 1'b1;
      end
      jss_pkg::ST_MACH: cur_mac <= mac_clamp;
      jss_pkg::ST_PTIME: begin
        cur_p <= opt_rdata;
        s_idx <= '0;
        limit <= JW'(lim_wide);
      end
      jss_pkg::ST_SLOT_RD: ;
      jss_pkg::ST_SLOT_EV: begin
        // slot 0 is the fallback; a later slot wins only when it fits and is tighter or none fit yet
        if (s_idx == '0) begin
          c_found <= fits;
          c_gap   <= gap;
          c_slot  <= '0;
          c_sb    <= slot_sb;
          c_sf    <= slot_sf;
        end else if (fits && (!c_found || gap < c_gap)) begin
          c_found <= 1'b1;
          c_gap   <= gap;
          c_slot  <= s_idx;
          c_sb    <= slot_sb;
          c_sf    <= slot_sf;
        end
        if (s_idx != limit) s_idx <= s_idx + 1'b1;
      end
      jss_pkg::ST_SCORE: ;
      jss_pkg::ST_SCORE_WAIT: begin
        if (score_stat.done) begin
          if (!have || score_stat.score > best_v) begin
            have       <= 1'b1;
            best_v     <= score_stat.score;
            best_job   <= cur_job;
            best_mac   <= cur_mac;
            best_slot  <= c_slot;
            best_start <= start_c;
            best_sb    <= c_sb;
            best_sf    <= c_sf;
            best_p     <= cur_p;
          end
          if (!last_job) cur_job <= cur_job + 1'b1;
        end
      end
      jss_pkg::ST_COMMIT: begin
        if (commit_fire) begin
          job_left[best_job]  <= (r_jleft > TIME_W'(best_p)) ? r_jleft - TIME_W'(best_p) : '0;
          mach_left[best_mac] <= (r_mleft > TIME_W'(best_p)) ? r_mleft - TIME_W'(best_p) : '0;
          job_ready[best_job] <= best_sp;
          mach_fin[best_mac]  <= fin_new;
          makespan            <= mk_new;
          job_ops[best_job]   <= r_jops + 1'b1;
          if (r_mops < jss_pkg::CNT_MAX) mach_ops[best_mac] <= r_mops + 1'b1;
          fin_step <= (step_cnt + 1'b1) == total;
          step_cnt <= step_cnt + 1'b1;
          o_job    <= 3'(best_job);
          o_mac    <= 3'(best_mac);
          o_start  <= best_start;
          o_var    <= 6'(32'(best_mac) * 32'(n_use) + 32'(best_job));
          o_ub     <= best_sb;
          o_ue     <= best_sf;
          o_mk     <= mk_new;
          o_last   <= (step_cnt + 1'b1) == total;
        end
      end
      jss_pkg::ST_SPLIT: begin
        cur_job <= '0;
        have    <= 1'b0;
      end
      default: ;
    endcase
  end

  // result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_ch.ready            = (state == jss_pkg::ST_IDLE);
  assign out_ch.valid           = out_valid;
  assign out_ch.step_job        = o_job;
  assign out_ch.step_machine    = o_mac;
  assign out_ch.start_time      = o_start;
  assign out_ch.var_index       = o_var;
  assign out_ch.used_slot_start = o_ub;
  assign out_ch.used_slot_end   = o_ue;
  assign out_ch.makespan        = o_mk;
  assign out_ch.last            = o_last;

  // checks
  a_score_done_waited: assert property (@(posedge clk) disable iff (rst)
    score_stat.done |-> state == jss_pkg::ST_SCORE_WAIT)
    else $error("score finished outside its wait state");

  a_slot_in_limit: assert property (@(posedge clk) disable iff (rst)
    state == jss_pkg::ST_SLOT_EV |-> s_idx <= limit)
    else $error("slot search ran past its limit");

  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    commit_fire |-> !out_valid || out_ch.ready)
    else $error("result word overwritten before taken");

  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    state == jss_pkg::ST_SPLIT && fin_step |=> state == jss_pkg::ST_IDLE)
    else $error("run did not end after final step");

endmodule

// ===== test/job_shop_insertion_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// job_shop_insertion_scheduler_test: self-checking bench of the scheduler
// Loads routings, processing times and weights, then runs schedules under
// several job and machine counts. A directed table comes first, random
// phases follow. Each result word is checked field by field against the
// table or a behavioral scheduler in the bench. Both channels idle at random.
// ----------------------------------------------------------------------------
module job_shop_insertion_scheduler_test;

  localparam int IDLE_LIMIT = 20000;
  localparam int WORD_GOAL  = 270;
  localparam int HOLD_LEN   = 600;

  // item kind with no meaning, the block must ignore it
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0]  job;
    logic [2:0]  mach;
    logic [17:0] start;
    logic [5:0]  var_idx;
    logic [17:0] slot_lo;
    logic [19:0] slot_hi;
    logic [17:0] span;
    logic        last;
  } step_rec_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  job;
    logic [2:0]  op;
    logic [2:0]  mach;
    logic [11:0] proc;
    logic [3:0]  widx;
    logic [15:0] wval;
  } word_t;

  typedef struct packed {
    bit                            is_cfg;
    logic [jss_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [jss_pkg::CFG_W-1:0]     cfg_val;
    word_t                         w;
    bit                            typed;
    step_rec_t                     exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                          cfg_write;
  logic [jss_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [jss_pkg::CFG_W-1:0]     cfg_data;

  jss_in_if  in_ch();
  jss_out_if out_ch();

  job_shop_insertion_scheduler u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scheduler mirror: stored tables, weights and registers
  int unsigned proc_tab [8][8];
  int unsigned route_tab [8][8];
  int          weight_tab [14];
  logic [3:0]  jobs_reg;
  logic [3:0]  mach_reg;

  step_rec_t step_q [$];
  row_t      rows [$];

  int  errors;
  int  words_in;
  int  steps_seen;
  int  runs_done;
  int  idle_cycles;
  int  hold_left;
  int  stall_left;
  bit  hold_req;
  bit  quiet_src;
  bit  quiet_snk;

  function automatic int unsigned umax(int unsigned a, int unsigned b);
    return a > b ? a : b;
  endfunction

  function automatic int unsigned eff_count(logic [3:0] v);
    if (v == 4'd0) return 1;
    return v > 4'd8 ? 8 : int'(v);
  endfunction

  // build a full schedule from the mirror state, queue its step words
  function automatic void build_schedule(input bit keep);
    int unsigned n, m, total, step, j, k, sl, mac, p, start, mfin, lim, lo;
    int unsigned op, cnt, ub, ue, bj, bm, bs, bst, span;
    int unsigned rdy [8], jdone [8], mdone [8], mfn [8];
    int unsigned jleft [8], jtot [8], mleft [8];
    int unsigned sb [8][8], sf [8][8];
    longint gap, bgap, score, bscore;
    longint phi [14];
    bit have, found;
    step_rec_t r;
    n = eff_count(jobs_reg);
    m = eff_count(mach_reg);
    for (k = 0; k < 8; k++) begin
      rdy[k] = 0; jdone[k] = 0; mdone[k] = 0; mfn[k] = 0;
      jleft[k] = 0; jtot[k] = 0; mleft[k] = 0;
      for (sl = 0; sl < 8; sl++) begin
        sb[k][sl] = 0;
        sf[k][sl] = (sl == 0) ? jss_pkg::OPEN_END : 0;
      end
    end
    span = 0;
    for (j = 0; j < n; j++) begin
      for (k = 0; k < m; k++) begin
        jleft[j] += proc_tab[j][k];
        jtot[j]  += proc_tab[j][k];
        mleft[k] += proc_tab[j][k];
      end
    end
    total = n * m;
    if (total > jss_pkg::MAX_RESULTS) total = jss_pkg::MAX_RESULTS;
    for (step = 0; step < total; step++) begin
      have = 0; bscore = 0; bj = 0; bm = 0; bs = 0; bst = 0;
      for (j = 0; j < n; j++) begin
        if (jdone[j] >= m) continue;
        op = jdone[j] > 7 ? 7 : jdone[j];
        mac = route_tab[j][op];
        if (mac >= m) mac = m - 1;
        p = proc_tab[j][mac];
        // tightest slot that fits, first one on a tie
        lim = mdone[mac];
        if (lim > n - 1) lim = n - 1;
        found = 0; bgap = 0; sl = 0;
        for (k = 0; k <= lim; k++) begin
          lo = umax(sb[mac][k], rdy[j]);
          gap = longint'(sf[mac][k]) - longint'(lo);
          if (gap >= longint'(p) && (!found || gap < bgap)) begin
            found = 1; bgap = gap; sl = k;
          end
        end
        start = umax(rdy[j], sb[mac][sl]);
        mfin = umax(mfn[mac], start + p);
        phi[jss_pkg::FEAT_MACHINE]    = mac + 1;
        phi[jss_pkg::FEAT_START]      = start;
        phi[jss_pkg::FEAT_READY]      = rdy[j];
        phi[jss_pkg::FEAT_WORK_LEFT]  = jleft[j];
        phi[jss_pkg::FEAT_PTIME]      = p;
        phi[jss_pkg::FEAT_OPS_DONE]   = jdone[j];
        phi[jss_pkg::FEAT_WORK_TOTAL] = jtot[j];
        phi[jss_pkg::FEAT_WAIT]       = longint'(start) - longint'(rdy[j]);
        phi[jss_pkg::FEAT_INSERT]     = (sf[mac][sl] != jss_pkg::OPEN_END);
        phi[jss_pkg::FEAT_MACH_FIN]   = mfin;
        phi[jss_pkg::FEAT_MAKESPAN]   = umax(span, mfin);
        phi[jss_pkg::FEAT_MACH_WORK]  = mleft[mac];
        phi[jss_pkg::FEAT_GAP]        = longint'(start) - longint'(sb[mac][sl]);
        phi[jss_pkg::FEAT_FINISH]     = longint'(start) + p;
        score = 0;
        for (k = 0; k < jss_pkg::NUM_FEATURES; k++) score += phi[k] * weight_tab[k];
        if (!have || score > bscore) begin
          have = 1; bscore = score; bj = j; bm = mac; bs = sl; bst = start;
        end
      end
      if (!have) break;
      // commit: split the slot and advance the job and machine
      p = proc_tab[bj][bm];
      ub = sb[bm][bs];
      ue = sf[bm][bs];
      cnt = mdone[bm];
      jleft[bj] = jleft[bj] > p ? jleft[bj] - p : 0;
      mleft[bm] = mleft[bm] > p ? mleft[bm] - p : 0;
      if (cnt < n - 1) begin
        sf[bm][cnt + 1] = ue;
        sb[bm][cnt + 1] = bst + p;
      end
      sf[bm][bs] = bst;
      rdy[bj] = bst + p;
      mfn[bm] = umax(mfn[bm], rdy[bj]);
      if (mfn[bm] > span) span = mfn[bm];
      jdone[bj] += 1;
      if (mdone[bm] < jss_pkg::CNT_MAX) mdone[bm] += 1;
      r.job     = bj[2:0];
      r.mach    = bm[2:0];
      r.start   = bst[17:0];
      r.var_idx = 6'((bm * n + bj) & 6'h3F);
      r.slot_lo = ub[17:0];
      r.slot_hi = ue[19:0];
      r.span    = span[17:0];
      r.last    = (step + 1 == total);
      if (keep) step_q.push_back(r);
    end
  endfunction

  function automatic void apply_word(input word_t w, input bit keep);
    case (w.kind)
      jss_pkg::KIND_LOAD_OP: begin
        route_tab[w.job][w.op] = w.mach;
        proc_tab[w.job][w.mach] = w.proc;
      end
      jss_pkg::KIND_LOAD_WEIGHT:
        if (w.widx < jss_pkg::NUM_FEATURES) weight_tab[w.widx] = int'($signed(w.wval));
      jss_pkg::KIND_RUN: begin
        build_schedule(keep);
        runs_done++;
      end
      default: ;
    endcase
  endfunction

  // sender: optional gap, then hold the word until it is taken
  task automatic send_word(input word_t w, input bit keep);
    int gap;
    gap = 0;
    if (!quiet_src && $urandom_range(0, 9) >= 7)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.kind         = w.kind;
    in_ch.job_index    = w.job;
    in_ch.op_index     = w.op;
    in_ch.machine_id   = w.mach;
    in_ch.proc_time    = w.proc;
    in_ch.weight_index = w.widx;
    in_ch.weight_value = w.wval;
    do @(posedge clk); while (!in_ch.ready);
    apply_word(w, keep);
    if (w.kind != KIND_SPARE &&
        !(w.kind == jss_pkg::KIND_LOAD_WEIGHT && w.widx >= jss_pkg::NUM_FEATURES))
      words_in++;
  endtask

  // idle point: every step word back, then let the block settle
  task automatic drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (step_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [jss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jss_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == jss_pkg::REG_JOBS) jobs_reg = val;
    else mach_reg = val;
  endtask

  function automatic word_t mk_word(logic [1:0] kind, int job, int op, int mach, int proc,
                                    int widx, int wval);
    word_t w;
    w.kind = kind;
    w.job  = job[2:0];
    w.op   = op[2:0];
    w.mach = mach[2:0];
    w.proc = proc[11:0];
    w.widx = widx[3:0];
    w.wval = wval[15:0];
    return w;
  endfunction

  function automatic word_t rand_word(logic [1:0] kind);
    int proc, wval;
    proc = $urandom_range(0, 4095);
    if ($urandom_range(0, 9) == 0) proc = $urandom_range(0, 1) ? 4095 : 0;
    wval = $urandom_range(0, 65535);
    if ($urandom_range(0, 9) == 0) wval = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    return mk_word(kind, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                   proc, $urandom_range(0, 13), wval);
  endfunction

  function automatic void add_cfg(logic [jss_pkg::CFG_IDX_W-1:0] idx,
                                  logic [jss_pkg::CFG_W-1:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1; r.cfg_idx = idx; r.cfg_val = val;
    rows.push_back(r);
  endfunction

  function automatic void add_word(word_t w, bit typed, step_rec_t exp);
    row_t r;
    r = '0;
    r.w = w; r.typed = typed; r.exp = exp;
    rows.push_back(r);
  endfunction

  function automatic void check_field(string name, longint exp, longint act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endfunction

  // result side: random stalls, and one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_LEN;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (!quiet_snk && $urandom_range(0, 9) >= 7) begin
      stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // result check against the oldest pending step word
  always @(posedge clk) begin
    step_rec_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      steps_seen++;
      if (step_q.size() == 0) begin
        $error("step word with nothing pending: job %0d machine %0d",
               out_ch.step_job, out_ch.step_machine);
        errors++;
      end else begin
        e = step_q.pop_front();
        check_field("step_job", e.job, out_ch.step_job);
        check_field("step_machine", e.mach, out_ch.step_machine);
        check_field("start_time", e.start, out_ch.start_time);
        check_field("var_index", e.var_idx, out_ch.var_index);
        check_field("used_slot_start", e.slot_lo, out_ch.used_slot_start);
        check_field("used_slot_end", e.slot_hi, out_ch.used_slot_end);
        check_field("makespan", e.span, out_ch.makespan);
        check_field("last", e.last, out_ch.last);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int ph, nl, i, j, r;
    step_rec_t ex;
    word_t w;
    in_ch.valid = 1'b0;
    in_ch.kind = '0; in_ch.job_index = '0; in_ch.op_index = '0; in_ch.machine_id = '0;
    in_ch.proc_time = '0; in_ch.weight_index = '0; in_ch.weight_value = '0;
    out_ch.ready = 1'b0;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; words_in = 0; steps_seen = 0; runs_done = 0; idle_cycles = 0;
    hold_left = 0; stall_left = 0; hold_req = 0; quiet_src = 0; quiet_snk = 0;
    jobs_reg = 4'd8; mach_reg = 4'd8;
    for (i = 0; i < jss_pkg::NUM_FEATURES; i++) weight_tab[i] = 0;
    for (i = 0; i < 8; i++)
      for (j = 0; j < 8; j++) begin
        proc_tab[i][j] = 0;
        route_tab[i][j] = 0;
      end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill every routing entry and weight before any run reads them
    for (i = 0; i < 8; i++)
      for (j = 0; j < 8; j++)
        send_word(mk_word(jss_pkg::KIND_LOAD_OP, i, j, j, $urandom_range(0, 4095), 0, 0), 1);
    for (i = 0; i < jss_pkg::NUM_FEATURES; i++) begin
      w = rand_word(jss_pkg::KIND_LOAD_WEIGHT);
      w.widx = i[3:0];
      send_word(w, 1);
    end

    // directed table
    ex = '0;
    add_cfg(jss_pkg::REG_JOBS, 4'd0);
    add_cfg(jss_pkg::REG_MACHINES, 4'd0);
    add_word(mk_word(jss_pkg::KIND_LOAD_OP, 0, 0, 0, 4095, 0, 0), 0, ex);
    ex = '{job: 0, mach: 0, start: 0, var_idx: 0, slot_lo: 0, slot_hi: jss_pkg::OPEN_END,
           span: 4095, last: 1};
    add_word(mk_word(jss_pkg::KIND_RUN, 0, 0, 0, 0, 0, 0), 1, ex);
    add_word(mk_word(jss_pkg::KIND_LOAD_OP, 0, 0, 0, 0, 0, 0), 0, ex);
    ex.span = 0;
    add_word(mk_word(jss_pkg::KIND_RUN, 7, 7, 7, 4095, 15, 16'hFFFF), 1, ex);
    add_word(mk_word(jss_pkg::KIND_LOAD_WEIGHT, 0, 0, 0, 0, 14, 7), 0, ex);
    add_word(mk_word(jss_pkg::KIND_LOAD_WEIGHT, 0, 0, 0, 0, 15, 16'h8000), 0, ex);
    add_word(mk_word(KIND_SPARE, 7, 7, 7, 4095, 15, 16'hFFFF), 0, ex);
    add_word(mk_word(jss_pkg::KIND_LOAD_WEIGHT, 0, 0, 0, 0, 0, 16'h8000), 0, ex);
    add_word(mk_word(jss_pkg::KIND_LOAD_WEIGHT, 0, 0, 0, 0, 13, 16'h7FFF), 0, ex);
    add_word(mk_word(jss_pkg::KIND_LOAD_WEIGHT, 0, 0, 0, 0, 4, 16'h0100), 0, ex);
    add_cfg(jss_pkg::REG_JOBS, 4'd15);
    add_cfg(jss_pkg::REG_MACHINES, 4'd2);
    // routing machines beyond the machine count fold onto the last one
    add_word(mk_word(jss_pkg::KIND_LOAD_OP, 7, 0, 7, 4095, 0, 0), 0, ex);
    add_word(mk_word(jss_pkg::KIND_LOAD_OP, 7, 1, 6, 4095, 0, 0), 0, ex);
    add_word(mk_word(jss_pkg::KIND_RUN, 0, 0, 0, 0, 0, 0), 0, ex);
    add_cfg(jss_pkg::REG_MACHINES, 4'd15);
    add_word(mk_word(jss_pkg::KIND_RUN, 0, 0, 0, 0, 0, 0), 0, ex);
    add_cfg(jss_pkg::REG_JOBS, 4'd3);
    add_cfg(jss_pkg::REG_MACHINES, 4'd3);
    add_word(mk_word(jss_pkg::KIND_LOAD_OP, 1, 0, 2, 0, 0, 0), 0, ex);
    add_word(mk_word(jss_pkg::KIND_RUN, 0, 0, 0, 0, 0, 0), 0, ex);

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        drain();
        write_reg(rows[k].cfg_idx, rows[k].cfg_val);
      end else begin
        send_word(rows[k].w, !rows[k].typed);
        if (rows[k].typed) step_q.push_back(rows[k].exp);
      end
    end

    // random phases: new sizes, a batch of loads, then one or two runs
    ph = 0;
    while (words_in < WORD_GOAL) begin
      ph++;
      drain();
      quiet_src = ($urandom_range(0, 4) == 0);
      quiet_snk = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      write_reg(jss_pkg::REG_JOBS,
                jss_pkg::CFG_W'(r < 6 ? $urandom_range(1, 3) : r < 8 ? $urandom_range(4, 8) :
                                r == 8 ? 0 : $urandom_range(9, 15)));
      r = $urandom_range(0, 9);
      write_reg(jss_pkg::REG_MACHINES,
                jss_pkg::CFG_W'(r < 6 ? $urandom_range(1, 3) : r < 8 ? $urandom_range(4, 8) :
                                r == 8 ? 0 : $urandom_range(9, 15)));
      nl = $urandom_range(2, 10);
      for (i = 0; i < nl; i++) begin
        r = $urandom_range(0, 19);
        if (r < 11) send_word(rand_word(jss_pkg::KIND_LOAD_OP), 1);
        else if (r < 18) send_word(rand_word(jss_pkg::KIND_LOAD_WEIGHT), 1);
        else begin
          w = rand_word(r == 18 ? KIND_SPARE : jss_pkg::KIND_LOAD_WEIGHT);
          if (r == 19) w.widx = 4'($urandom_range(14, 15));
          send_word(w, 1);
        end
      end
      if (ph == 3) hold_req = 1;
      send_word(mk_word(jss_pkg::KIND_RUN, $urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 4095), $urandom_range(0, 15),
                        $urandom_range(0, 65535)), 1);
      // with results held back, keep offering loads behind the run
      if (ph == 3)
        for (i = 0; i < 6; i++) send_word(rand_word(jss_pkg::KIND_LOAD_OP), 1);
      if ($urandom_range(0, 2) == 0)
        send_word(mk_word(jss_pkg::KIND_RUN, 0, 0, 0, 0, 0, 0), 1);
    end

    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d accepted words, %0d schedule runs, %0d step words checked",
             words_in, runs_done, steps_seen);
    if (errors == 0 && step_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
